// ===== hdl/crc_guarded_retained_store_assert.svh =====
// Assertion macros shared by the store RTL.
// No dependencies; taken in by `include where assertions are written.
`ifndef CRC_GUARDED_RETAINED_STORE_ASSERT_SVH
`define CRC_GUARDED_RETAINED_STORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== hdl/crcgrs_pkg.sv =====
// Package for the CRC-guarded retained store: codes, types, CRC constants
// and the byte-wide CRC-16 step. No dependencies.
`default_nettype none

package crcgrs_pkg;

   // Sizes
   localparam int MEM_BYTES_DEF    = 256;
   localparam int MAX_ACCESS_BYTES = 8;
   localparam int DATA_W           = 8 * MAX_ACCESS_BYTES;

   // CRC-16, MSB first, no final xor
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_SEED = 16'hAB12;

   // Request codes
   localparam logic [1:0] REQ_READ  = 2'd0;
   localparam logic [1:0] REQ_WRITE = 2'd1;
   localparam logic [1:0] REQ_INIT  = 2'd2;

   // Status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NOT_INIT = 2'd1;
   localparam logic [1:0] STATUS_RANGE    = 2'd2;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_READ,
      ST_WRITE,
      ST_SCAN,
      ST_CHECK,
      ST_PUT_LO,
      ST_PUT_HI
   } state_type;

   // What the byte coming back from the RAM is for
   typedef enum logic [1:0] {
      FK_NONE,
      FK_BODY,
      FK_LO,
      FK_HI
   } fetch_type;

   // One byte through the CRC, eight bit steps
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                              input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int b = 0; b < 8; b++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/crcgrs_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module crcgrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== hdl/crc_guarded_retained_store.sv =====
// Top level of the CRC-guarded retained store: byte RAM plus a byte-serial
// sequencer for access, CRC scan, verify and clear. Uses crcgrs_pkg, crcgrs_ram.
//
//   channel   | handshake               | word
//   ----------+-------------------------+-------------------------------------------
//   request   | start, busy             | req_type, req_offset, req_length, req_write_data
//   response  | rsp_valid (one cycle)   | rsp_status, rsp_read_data, rsp_was_cleared
//
// A rejected request is answered in the next cycle; a read gathers its bytes
// into their lanes. A write stores one byte per cycle, then the CRC scan runs
// over the body at one byte per cycle through the RAM read port. An init
// checks the stored CRC, and clears the store and rewrites the CRC on a mismatch.
// After reset a clearing pass holds busy high.
// The response strobe cannot be held off; busy is the only stall.
`default_nettype none

module crc_guarded_retained_store
   import crcgrs_pkg::*;
#(
   parameter int MEM_BYTES = MEM_BYTES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [1:0]        req_type,
   input  wire logic [7:0]        req_offset,
   input  wire logic [3:0]        req_length,
   input  wire logic [DATA_W-1:0] req_write_data,
   output logic                   rsp_valid,
   output logic      [1:0]        rsp_status,
   output logic      [DATA_W-1:0] rsp_read_data,
   output logic                   rsp_was_cleared
);

`include "crc_guarded_retained_store_assert.svh"

   localparam int AW    = $clog2(MEM_BYTES);
   localparam int CW    = $clog2(MEM_BYTES + 1);
   localparam int CMP_W = (CW > 9) ? CW : 9;

   localparam logic [CW-1:0]    BODY_C = CW'(MEM_BYTES - 2);
   localparam logic [CW-1:0]    LAST_C = CW'(MEM_BYTES - 1);
   localparam logic [CW-1:0]    FULL_C = CW'(MEM_BYTES);
   localparam logic [CMP_W-1:0] RD_LIM = CMP_W'(MEM_BYTES);
   localparam logic [CMP_W-1:0] WR_LIM = CMP_W'(MEM_BYTES - 2);
   localparam logic [3:0]       MAX_LEN = 4'(MAX_ACCESS_BYTES);

   // control state
   state_type        state_ff, state_in;
   fetch_type        fetch_ff, fetch_in;
   logic [CW-1:0]    scan_ff, scan_in;
   logic             init_done_ff, init_done_in;
   logic             post_ff, post_in;      // after a clear: recompute CRC
   logic             rsp_valid_ff, rsp_valid_in;

   // payload
   logic             verify_ff, verify_in;
   logic             cleared_ff, cleared_in;
   logic [15:0]      crc_ff, crc_in;
   logic [15:0]      stored_ff, stored_in;
   logic [7:0]       off_ff, off_in;
   logic [3:0]       len_ff, len_in;
   logic [3:0]       byte_ff, byte_in;
   logic [2:0]       cons_ff, cons_in;
   logic [DATA_W-1:0] wdata_ff, wdata_in;
   logic [DATA_W-1:0] rdata_ff, rdata_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0] rsp_rdata_ff, rsp_rdata_in;
   logic              rsp_cleared_ff, rsp_cleared_in;

   // RAM port
   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [7:0]    ram_wdata, ram_rdata;

   logic             accept;
   logic [CMP_W-1:0] req_end;
   logic [CMP_W-1:0] acc_addr;
   logic             len_bad;
   logic [DATA_W-1:0] rd_merge;

   crcgrs_ram #(
      .WIDTH (8),
      .DEPTH (MEM_BYTES)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // range checks on the request word
   assign req_end  = CMP_W'(req_offset) + CMP_W'(req_length);
   assign len_bad  = (req_length == 4'd0) || (req_length > MAX_LEN);
   assign acc_addr = CMP_W'(off_ff) + CMP_W'(byte_ff);

   // read byte dropped into its lane
   always_comb begin
      rd_merge = rdata_ff;
      rd_merge[{cons_ff, 3'b000} +: 8] = ram_rdata;
   end

   // sequencer: next state and outputs
   always_comb begin
      state_in       = state_ff;
      fetch_in       = FK_NONE;
      scan_in        = scan_ff;
      init_done_in   = init_done_ff;
      post_in        = post_ff;
      verify_in      = verify_ff;
      cleared_in     = cleared_ff;
      crc_in         = crc_ff;
      stored_in      = stored_ff;
      off_in         = off_ff;
      len_in         = len_ff;
      byte_in        = byte_ff;
      cons_in        = cons_ff;
      wdata_in       = wdata_ff;
      rdata_in       = rdata_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = STATUS_OK;
      rsp_rdata_in   = '0;
      rsp_cleared_in = 1'b0;
      ram_we         = 1'b0;
      ram_waddr      = acc_addr[AW-1:0];
      ram_wdata      = wdata_ff[7:0];
      ram_raddr      = acc_addr[AW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               off_in     = req_offset;
               len_in     = req_length;
               wdata_in   = req_write_data;
               rdata_in   = '0;
               byte_in    = 4'd0;
               cons_in    = 3'd0;
               cleared_in = 1'b0;
               scan_in    = '0;
               crc_in     = CRC_SEED;
               if (req_type == REQ_INIT) begin
                  init_done_in = 1'b1;
                  verify_in    = 1'b1;
                  state_in     = ST_SCAN;
               end else if (req_type != REQ_READ && req_type != REQ_WRITE) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_RANGE;
               end else if (!init_done_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_NOT_INIT;
               end else if (len_bad) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_RANGE;
               end else if (req_type == REQ_READ) begin
                  if (req_end > RD_LIM) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STATUS_RANGE;
                  end else begin
                     state_in = ST_READ;
                  end
               end else begin
                  if (req_end > WR_LIM) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STATUS_RANGE;
                  end else begin
                     verify_in = 1'b0;
                     state_in  = ST_WRITE;
                  end
               end
            end
         end

         // zero every byte, one a cycle
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = scan_ff[AW-1:0];
            ram_wdata = 8'h00;
            scan_in   = scan_ff + 1'b1;
            if (scan_ff == LAST_C) begin
               scan_in = '0;
               crc_in  = CRC_SEED;
               if (post_ff) begin
                  verify_in = 1'b0;
                  state_in  = ST_SCAN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         // issue byte reads, gather returning bytes into their lanes
         ST_READ: begin
            if (byte_ff != len_ff) begin
               fetch_in = FK_BODY;
               byte_in  = byte_ff + 1'b1;
            end
            if (fetch_ff == FK_BODY) begin
               rdata_in = rd_merge;
               cons_in  = cons_ff + 1'b1;
               if (byte_ff == len_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_rdata_in = rd_merge;
                  state_in     = ST_IDLE;
               end
            end
         end

         // store the word one byte a cycle
         ST_WRITE: begin
            ram_we   = 1'b1;
            wdata_in = {8'h00, wdata_ff[DATA_W-1:8]};
            byte_in  = byte_ff + 1'b1;
            if (byte_in == len_ff) begin
               state_in = ST_SCAN;
            end
         end

         // CRC over the body; on verify also fetch the stored CRC bytes
         ST_SCAN: begin
            ram_raddr = scan_ff[AW-1:0];
            if (scan_ff != (verify_ff ? FULL_C : BODY_C)) begin
               scan_in = scan_ff + 1'b1;
               if (scan_ff == BODY_C) begin
                  fetch_in = FK_LO;
               end else if (scan_ff == LAST_C) begin
                  fetch_in = FK_HI;
               end else begin
                  fetch_in = FK_BODY;
               end
            end else begin
               state_in = verify_ff ? ST_CHECK : ST_PUT_LO;
            end
            case (fetch_ff)
               FK_BODY: crc_in          = crc16_byte(crc_ff, ram_rdata);
               FK_LO:   stored_in[7:0]  = ram_rdata;
               FK_HI:   stored_in[15:8] = ram_rdata;
               default: ;
            endcase
         end

         // compare fresh CRC with the stored one
         ST_CHECK: begin
            if (crc_ff == stored_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               cleared_in = 1'b1;
               post_in    = 1'b1;
               scan_in    = '0;
               state_in   = ST_CLEAR;
            end
         end

         ST_PUT_LO: begin
            ram_we    = 1'b1;
            ram_waddr = BODY_C[AW-1:0];
            ram_wdata = crc_ff[7:0];
            state_in  = ST_PUT_HI;
         end

         ST_PUT_HI: begin
            ram_we         = 1'b1;
            ram_waddr      = LAST_C[AW-1:0];
            ram_wdata      = crc_ff[15:8];
            rsp_valid_in   = 1'b1;
            rsp_cleared_in = cleared_ff;
            state_in       = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         fetch_ff     <= FK_NONE;
         scan_ff      <= '0;
         init_done_ff <= 1'b0;
         post_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fetch_ff     <= fetch_in;
         scan_ff      <= scan_in;
         init_done_ff <= init_done_in;
         post_ff      <= post_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      verify_ff      <= verify_in;
      cleared_ff     <= cleared_in;
      crc_ff         <= crc_in;
      stored_ff      <= stored_in;
      off_ff         <= off_in;
      len_ff         <= len_in;
      byte_ff        <= byte_in;
      cons_ff        <= cons_in;
      wdata_ff       <= wdata_in;
      rdata_ff       <= rdata_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_rdata_ff   <= rsp_rdata_in;
      rsp_cleared_ff <= rsp_cleared_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_data   = rsp_rdata_ff;
   assign rsp_was_cleared = rsp_cleared_ff;

   // checks
   `ASSERT_IMPLY(a_rsp_has_cause, clock, reset, rsp_valid,
                 $past(start && !busy) || $past(busy))
   `ASSERT_IMPLY(a_cleared_only_ok, clock, reset, rsp_valid && rsp_was_cleared,
                 rsp_status == STATUS_OK)
   `ASSERT_IMPLY(a_no_data_on_error, clock, reset,
                 rsp_valid && (rsp_status != STATUS_OK), rsp_read_data == '0)
   `ASSERT_NEXT(a_accept_progresses, clock, reset, start && !busy,
                busy || rsp_valid)
   `ASSERT_IMPLY(a_no_write_on_read, clock, reset, state_ff == ST_READ, !ram_we)

endmodule

`default_nettype wire

// ===== tb/sv/crcgrs_store_checker.sv =====
`timescale 1ns / 1ps
// Response checker for the CRC-guarded retained store: keeps its own byte image
// and CRC, predicts the answer to every accepted word and compares each response.
// Depends on crcgrs_pkg.

module crcgrs_store_checker
   import crcgrs_pkg::*;
#(
   parameter int MEM_BYTES = MEM_BYTES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              busy,
   input  wire logic [1:0]        req_type,
   input  wire logic [7:0]        req_offset,
   input  wire logic [3:0]        req_length,
   input  wire logic [DATA_W-1:0] req_write_data,
   input  wire logic              rsp_valid,
   input  wire logic [1:0]        rsp_status,
   input  wire logic [DATA_W-1:0] rsp_read_data,
   input  wire logic              rsp_was_cleared,
   output int                     failures,
   output int                     outstanding,
   output int                     checked
);

   // Beyond this many, mismatches are only counted
   localparam int REPORT_LIMIT = 100;

   typedef struct packed {
      logic [1:0]        status;
      logic [DATA_W-1:0] read_data;
      logic              was_cleared;
   } answer_type;

   logic [7:0] image [MEM_BYTES];
   bit         opened;
   answer_type answers_due [$];
   int         slips;
   int         queued;
   int         compared;

   assign failures    = slips;
   assign outstanding = queued;
   assign checked     = compared;

   // CRC over the body, one bit at a time, MSB first
   function automatic logic [15:0] body_crc();
      logic [15:0] acc;
      logic        fb;
      acc = CRC_SEED;
      for (int i = 0; i < MEM_BYTES - 2; i++) begin
         for (int b = 7; b >= 0; b--) begin
            fb  = acc[15] ^ image[i][b];
            acc = {acc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
         end
      end
      return acc;
   endfunction

   // CRC kept low byte first in the last two bytes
   function automatic void seal_body();
      logic [15:0] crc;
      crc = body_crc();
      image[MEM_BYTES-2] = crc[7:0];
      image[MEM_BYTES-1] = crc[15:8];
   endfunction

   // Apply one request word to the image and return the answer it should get
   function automatic answer_type serve_request(input logic [1:0]        kind,
                                                input logic [7:0]        off,
                                                input logic [3:0]        len,
                                                input logic [DATA_W-1:0] data);
      answer_type  ans;
      int          last;
      logic [15:0] held;
      ans  = '0;
      last = int'(off) + int'(len);
      if (kind == REQ_INIT) begin
         held = {image[MEM_BYTES-1], image[MEM_BYTES-2]};
         if (held != body_crc()) begin
            foreach (image[i]) image[i] = 8'h00;
            seal_body();
            ans.was_cleared = 1'b1;
         end
         opened = 1'b1;
      end else if (kind != REQ_READ && kind != REQ_WRITE) begin
         ans.status = STATUS_RANGE;
      end else if (!opened) begin
         ans.status = STATUS_NOT_INIT;
      end else if (len == 4'd0 || int'(len) > MAX_ACCESS_BYTES) begin
         ans.status = STATUS_RANGE;
      end else if (kind == REQ_READ) begin
         // reads may cover the CRC bytes
         if (last > MEM_BYTES)
            ans.status = STATUS_RANGE;
         else
            for (int i = 0; i < int'(len); i++)
               ans.read_data[8*i +: 8] = image[int'(off) + i];
      end else begin
         // writes must stop short of the CRC bytes
         if (last > MEM_BYTES - 2) begin
            ans.status = STATUS_RANGE;
         end else begin
            for (int i = 0; i < int'(len); i++)
               image[int'(off) + i] = data[8*i +: 8];
            seal_body();
         end
      end
      return ans;
   endfunction

   function automatic void flag(input string field, input logic [DATA_W-1:0] want,
                                input logic [DATA_W-1:0] got);
      slips++;
      if (slips <= REPORT_LIMIT)
         $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
   endfunction

   // Accepted words first, then the response of this cycle
   always @(posedge clock) begin : watch
      answer_type want;
      if (reset) begin
         foreach (image[i]) image[i] = 8'h00;
         opened = 1'b0;
         answers_due.delete();
         queued = 0;
      end else begin
         if (start && !busy)
            answers_due.push_back(serve_request(req_type, req_offset, req_length,
                                                req_write_data));
         if (rsp_valid) begin
            if (answers_due.size() == 0) begin
               slips++;
               if (slips <= REPORT_LIMIT)
                  $error("response with none due: status %0d, data 0x%0h, cleared %0b",
                         rsp_status, rsp_read_data, rsp_was_cleared);
            end else begin
               want = answers_due.pop_front();
               if (rsp_status !== want.status)
                  flag("status", DATA_W'(want.status), DATA_W'(rsp_status));
               if (rsp_read_data !== want.read_data)
                  flag("read_data", want.read_data, rsp_read_data);
               if (rsp_was_cleared !== want.was_cleared)
                  flag("was_cleared", DATA_W'(want.was_cleared), DATA_W'(rsp_was_cleared));
               compared++;
            end
         end
         queued = answers_due.size();
      end
   end

endmodule

// ===== tb/sv/crc_guarded_retained_store_test.sv =====
`timescale 1ns / 1ps
// Top of the store testbench: clock, reset, directed and random request words.
// Depends on crcgrs_pkg, crc_guarded_retained_store and crcgrs_store_checker.

module crc_guarded_retained_store_test
   import crcgrs_pkg::*;
();

   // The one request code the block does not define
   localparam logic [1:0] REQ_UNDEFINED = 2'd3;
   localparam int RANDOM_WORDS  = 800;
   localparam int SETTLE_CYCLES = 800;
   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   logic              clock          = 1'b0;
   logic              reset          = 1'b1;
   logic              start          = 1'b0;
   logic [1:0]        req_type       = REQ_READ;
   logic [7:0]        req_offset     = 8'h00;
   logic [3:0]        req_length     = 4'd1;
   logic [DATA_W-1:0] req_write_data = '0;
   logic              busy;
   logic              rsp_valid;
   logic [1:0]        rsp_status;
   logic [DATA_W-1:0] rsp_read_data;
   logic              rsp_was_cleared;

   int   failures, outstanding, checked;
   int   n_read, n_write, n_init, n_odd;
   bit   idle_on = 1'b1;
   logic [7:0] last_write_off = 8'h00;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   crc_guarded_retained_store dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_offset      (req_offset),
      .req_length      (req_length),
      .req_write_data  (req_write_data),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_read_data   (rsp_read_data),
      .rsp_was_cleared (rsp_was_cleared)
   );

   crcgrs_store_checker store_check (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_offset      (req_offset),
      .req_length      (req_length),
      .req_write_data  (req_write_data),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_read_data   (rsp_read_data),
      .rsp_was_cleared (rsp_was_cleared),
      .failures        (failures),
      .outstanding     (outstanding),
      .checked         (checked)
   );

   // Present one word, after a random gap when idle_on is set; returns at the falling edge after acceptance
   task automatic send_word(input logic [1:0] kind, input logic [7:0] off,
                            input logic [3:0] len, input logic [63:0] data);
      int gap;
      gap = idle_on ? $urandom_range(0, 7) : 0;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start          <= 1'b1;
      req_type       <= kind;
      req_offset     <= off;
      req_length     <= len;
      req_write_data <= data;
      case (kind)
         REQ_READ:  n_read++;
         REQ_WRITE: n_write++;
         REQ_INIT:  n_init++;
         default:   n_odd++;
      endcase
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // before init: refused, unknown code still a range error
      send_word(REQ_READ,      8'h00, 4'd1, 64'h0);
      send_word(REQ_WRITE,     8'h00, 4'd8, ALL_ONES);
      send_word(REQ_UNDEFINED, 8'h00, 4'd1, 64'h0);
      send_word(REQ_READ,      8'h00, 4'd0, 64'h0);
      // first init finds a bad CRC and clears; the second verifies again
      send_word(REQ_INIT,      8'h00, 4'd1, 64'h0);
      send_word(REQ_INIT,      8'hFF, 4'd15, ALL_ONES);
      // read range, CRC bytes included
      send_word(REQ_READ,      8'd254, 4'd2, 64'h0);
      send_word(REQ_READ,      8'd255, 4'd1, 64'h0);
      send_word(REQ_READ,      8'd255, 4'd2, 64'h0);
      send_word(REQ_READ,      8'd248, 4'd8, 64'h0);
      send_word(REQ_READ,      8'd249, 4'd8, 64'h0);
      // write range, last legal byte just below the CRC
      send_word(REQ_WRITE,     8'd246, 4'd8, ALL_ONES);
      send_word(REQ_WRITE,     8'd247, 4'd8, ALL_ONES);
      send_word(REQ_WRITE,     8'd253, 4'd1, 64'h5555_5555_5555_55AA);
      send_word(REQ_WRITE,     8'd254, 4'd1, 64'h0);
      // bad lengths
      send_word(REQ_READ,      8'h00, 4'd0,  64'h0);
      send_word(REQ_WRITE,     8'h00, 4'd9,  ALL_ONES);
      send_word(REQ_READ,      8'h00, 4'd15, 64'h0);
      // data beyond the length must be dropped
      send_word(REQ_WRITE,     8'h00, 4'd8, 64'h0123_4567_89AB_CDEF);
      send_word(REQ_WRITE,     8'h03, 4'd2, ALL_ONES);
      send_word(REQ_READ,      8'h00, 4'd8, 64'h0);
      send_word(REQ_READ,      8'd246, 4'd8, 64'h0);
      send_word(REQ_UNDEFINED, 8'hFF, 4'd8, ALL_ONES);
      send_word(REQ_INIT,      8'h00, 4'd1, 64'h0);
      send_word(REQ_READ,      8'd248, 4'd8, 64'h0);

      // random words, mostly legal accesses so the image fills with data
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         int         pick;
         logic [1:0] kind;
         logic [7:0] off;
         logic [3:0] len;
         if (n % 100 == 0)
            idle_on = ($urandom_range(0, 2) != 0);
         pick = $urandom_range(0, 99);
         len  = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(0, 15))
                                              : 4'($urandom_range(1, 8));
         off  = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(240, 255))
                                             : 8'($urandom);
         if (pick < 42)
            kind = REQ_READ;
         else if (pick < 86)
            kind = REQ_WRITE;
         else if (pick < 95)
            kind = REQ_INIT;
         else
            kind = REQ_UNDEFINED;
         // read back recent writes now and then
         if (kind == REQ_READ && $urandom_range(0, 3) == 0)
            off = last_write_off;
         if (kind == REQ_WRITE)
            last_write_off = off;
         send_word(kind, off, len, {$urandom, $urandom});
      end
      start <= 1'b0;

      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d words: %0d reads, %0d writes, %0d inits, %0d undefined codes",
               n_read + n_write + n_init + n_odd, n_read, n_write, n_init, n_odd);
      $display("Compared %0d responses, %0d mismatches", checked, failures);
      if (failures == 0 && outstanding == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // Guard against a hung handshake
   initial begin
      #5_000_000;
      $error("run timed out with %0d responses outstanding", outstanding);
      $display("FAIL");
      $finish;
   end

endmodule
